// File: rtl/core/shallow_water_muscl_minmod_faces_unit_assert.svh
// Assertion macros used by the checker file of the face reconstruction unit.
`ifndef SHALLOW_WATER_MUSCL_MINMOD_FACES_UNIT_ASSERT_SVH
`define SHALLOW_WATER_MUSCL_MINMOD_FACES_UNIT_ASSERT_SVH

// same-cycle implication
`define SWMF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swmf assertion failed");

// next-cycle implication
`define SWMF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swmf assertion failed");

`endif

// File: rtl/core/swmf_pkg.sv
// Types and constants of the shallow water face reconstruction unit.
package swmf_pkg;

   localparam int unsigned DEPTH_W = 31;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned QUO_W   = 35;
   localparam int unsigned DIV_STEPS = QUO_W;

   typedef struct packed {
      logic [DEPTH_W-1:0]       h;
      logic signed [VAL_W-1:0]  u;
      logic signed [VAL_W-1:0]  v;
      logic signed [VAL_W-1:0]  z;
   } cell_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]      fdep;
      logic signed [VAL_W-1:0] fbed;
      logic [VAL_W-1:0]        opp;
      logic [VAL_W:0]          mu_mag;
      logic                    mu_neg;
      logic [VAL_W:0]          mv_mag;
      logic                    mv_neg;
   } face_type;

   typedef struct packed {
      logic       load;
      logic       prep;
      logic       mul;
      logic       div_init;
      logic       div_step;
      logic       store;
      logic       out_load;
      logic [1:0] job;
   } cmd_type;

   typedef struct packed {
      logic produce;
      logic out_free;
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PREP  = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_DINIT = 7'b0001000,
      ST_DSTEP = 7'b0010000,
      ST_STORE = 7'b0100000,
      ST_OUTW  = 7'b1000000
   } state_type;

endpackage

// File: rtl/core/swmf_ctrl.sv
// Sequencer of the face reconstruction unit: one cell at a time, four divider jobs.
module swmf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  swmf_pkg::status_type status,
   output swmf_pkg::cmd_type    cmd
);
   import swmf_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] job_ff, job_in;
   logic [5:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.job  = job_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            job_in   = '0;
            state_in = status.produce ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = 6'(DIV_STEPS - 1);
            state_in     = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 6'd1;
            if (cnt_ff == '0) state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            job_in    = job_ff + 2'd1;
            state_in  = (job_ff == 2'd3) ? ST_OUTW : ST_MUL;
         end
         ST_OUTW: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/core/swmf_datapath.sv
// Window, slope limiting, face arithmetic, shared multiplier and serial divider.
module swmf_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  swmf_pkg::cmd_type         cmd,
   output swmf_pkg::status_type      status,
   input  logic                      in_row_start,
   input  swmf_pkg::cell_type        in_cell,
   input  logic                      rsp_tready,
   output logic                      rsp_valid,
   output logic [swmf_pkg::DEPTH_W-1:0] out_fdep [2],
   output logic [swmf_pkg::VAL_W-1:0]   out_fu [2],
   output logic [swmf_pkg::VAL_W-1:0]   out_fv [2],
   output logic [swmf_pkg::VAL_W-1:0]   out_fz [2],
   output logic                      out_dry
);
   import swmf_pkg::*;

   function automatic logic signed [33:0] minmod(logic signed [33:0] a, logic signed [33:0] b);
      logic signed [33:0] r;
      if (!a[33] && !b[33]) r = (a < b) ? a : b;
      else if ((a[33] || a == 0) && (b[33] || b == 0)) r = (a > b) ? a : b;
      else r = '0;
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat32(logic signed [36:0] x);
      logic signed [VAL_W-1:0] r;
      if (x > 37'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < -37'sh0_8000_0000) r = 32'sh8000_0000;
      else r = x[VAL_W-1:0];
      return r;
   endfunction

   // face of cell c; right = 1 for its right face
   function automatic face_type calc_face(cell_type p, cell_type c, cell_type n, logic right);
      face_type f;
      logic signed [33:0] hp, hc, hn, dh1, dh2, mh, hh, fh, op, mz, mu, mv;
      logic signed [34:0] dz, hz;
      logic signed [36:0] zf;
      hp  = $signed({3'b0, p.h});
      hc  = $signed({3'b0, c.h});
      hn  = $signed({3'b0, n.h});
      dh1 = hc - hp;
      dh2 = hn - hc;
      mh  = minmod(dh1, dh2);
      hh  = mh >>> 1;
      mu  = minmod(34'(c.u) - 34'(p.u), 34'(n.u) - 34'(c.u));
      mv  = minmod(34'(c.v) - 34'(p.v), 34'(n.v) - 34'(c.v));
      mz  = minmod(34'(c.z) - 34'(p.z) + dh1, 34'(n.z) - 34'(c.z) + dh2);
      dz  = 35'(mz) - 35'(mh);
      hz  = dz >>> 1;
      fh  = right ? hc + hh : hc - hh;
      op  = right ? hc - hh : hc + hh;
      zf  = right ? 37'(c.z) + 37'(hz) : 37'(c.z) - 37'(hz);
      if (fh[33]) f.fdep = '0;
      else if (fh > 34'sh0_7FFF_FFFF) f.fdep = '1;
      else f.fdep = fh[DEPTH_W-1:0];
      f.opp    = op[33] ? '0 : op[VAL_W-1:0];
      f.fbed   = sat32(zf);
      f.mu_neg = mu[33];
      f.mu_mag = mu[33] ? 33'(-mu) : mu[VAL_W:0];
      f.mv_neg = mv[33];
      f.mv_mag = mv[33] ? 33'(-mv) : mv[VAL_W:0];
      return f;
   endfunction

   cell_type win_ff [3];
   cell_type win_eff [3];
   cell_type d_ff;
   logic     rs_ff;
   logic [1:0] seen_ff, seen_eff;

   face_type fc_l, fc_r;
   logic [DEPTH_W-1:0] fdep_ff [2];
   logic [VAL_W-1:0]   fz_ff [2];
   logic [VAL_W-1:0]   opp_ff [2];
   logic [DEPTH_W-1:0] hf_ff [2];
   logic [VAL_W-1:0]   vc_ff [4];
   logic [VAL_W:0]     mag_ff [4];
   logic               neg_ff [4];
   logic [VAL_W-1:0]   vres_ff [4];
   logic               dry_ff;

   logic [63:0]      prod_ff, mlo;
   logic             ovf_ff;
   logic [VAL_W-1:0] rem_ff;
   logic [QUO_W-1:0] plow_ff, q_ff, qc;
   logic [VAL_W:0]   tmp;
   logic [VAL_W-1:0] dvs;
   logic             fsel, add, qbit;
   logic signed [36:0] vsum;
   logic             valid_ff;

   assign fsel = cmd.job[1];
   assign dvs  = {hf_ff[fsel], 1'b0};
   assign mlo  = mag_ff[cmd.job][VAL_W-1:0] * opp_ff[fsel];
   assign tmp  = {rem_ff, plow_ff[QUO_W-1]};
   assign qbit = (tmp >= {1'b0, dvs});

   always_comb begin
      for (int i = 0; i < 3; i++) win_eff[i] = rs_ff ? '0 : win_ff[i];
      seen_eff = rs_ff ? 2'd0 : seen_ff;
   end

   assign fc_l = calc_face(win_eff[0], win_eff[1], win_eff[2], 1'b1);
   assign fc_r = calc_face(win_eff[1], win_eff[2], d_ff, 1'b0);

   // quotient clamped to 2^34
   always_comb begin
      if (hf_ff[fsel] == '0) qc = '0;
      else if (ovf_ff || q_ff > {1'b1, 34'b0}) qc = {1'b1, 34'b0};
      else qc = q_ff;
      add  = (fsel == 1'b0) ^ neg_ff[cmd.job];
      vsum = add ? 37'($signed(vc_ff[cmd.job])) + $signed({2'b0, qc})
                 : 37'($signed(vc_ff[cmd.job])) - $signed({2'b0, qc});
   end

   assign status.produce  = (seen_eff == 2'd3);
   assign status.out_free = !valid_ff || rsp_tready;
   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) win_ff[i] <= '0;
         seen_ff  <= '0;
         rs_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.load) rs_ff <= in_row_start;
         if (cmd.prep) begin
            win_ff[0] <= win_eff[1];
            win_ff[1] <= win_eff[2];
            win_ff[2] <= d_ff;
            seen_ff   <= (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;
            rs_ff     <= 1'b0;
         end
         if (cmd.out_load) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) d_ff <= in_cell;
      if (cmd.prep) begin
         fdep_ff[0] <= fc_l.fdep;  fdep_ff[1] <= fc_r.fdep;
         fz_ff[0]   <= fc_l.fbed;  fz_ff[1]   <= fc_r.fbed;
         opp_ff[0]  <= fc_l.opp;   opp_ff[1]  <= fc_r.opp;
         hf_ff[0]   <= win_eff[1].h;
         hf_ff[1]   <= win_eff[2].h;
         vc_ff[0] <= win_eff[1].u; vc_ff[1] <= win_eff[1].v;
         vc_ff[2] <= win_eff[2].u; vc_ff[3] <= win_eff[2].v;
         mag_ff[0] <= fc_l.mu_mag; neg_ff[0] <= fc_l.mu_neg;
         mag_ff[1] <= fc_l.mv_mag; neg_ff[1] <= fc_l.mv_neg;
         mag_ff[2] <= fc_r.mu_mag; neg_ff[2] <= fc_r.mu_neg;
         mag_ff[3] <= fc_r.mv_mag; neg_ff[3] <= fc_r.mv_neg;
         dry_ff <= (win_eff[1].h == '0) || (win_eff[2].h == '0);
      end
      // magnitude is at most 2^32: top bit adds opp shifted up
      if (cmd.mul)
         prod_ff <= mlo + (mag_ff[cmd.job][VAL_W] ? {opp_ff[fsel], 32'b0} : 64'd0);
      if (cmd.div_init) begin
         ovf_ff  <= ({3'b0, prod_ff[63:QUO_W]} >= dvs);
         rem_ff  <= {3'b0, prod_ff[63:QUO_W]};
         plow_ff <= prod_ff[QUO_W-1:0];
         q_ff    <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= qbit ? 32'(tmp - {1'b0, dvs}) : tmp[VAL_W-1:0];
         plow_ff <= {plow_ff[QUO_W-2:0], 1'b0};
         q_ff    <= {q_ff[QUO_W-2:0], qbit};
      end
      if (cmd.store) vres_ff[cmd.job] <= sat32(vsum);
      if (cmd.out_load) begin
         out_fdep[0] <= fdep_ff[0]; out_fdep[1] <= fdep_ff[1];
         out_fz[0]   <= fz_ff[0];   out_fz[1]   <= fz_ff[1];
         out_fu[0]   <= vres_ff[0]; out_fv[0]   <= vres_ff[1];
         out_fu[1]   <= vres_ff[2]; out_fv[1]   <= vres_ff[3];
         out_dry     <= dry_ff;
      end
   end

endmodule

// File: rtl/core/shallow_water_muscl_minmod_faces_unit.sv
// Top level of the MUSCL minmod face reconstruction unit.
// Takes one grid cell per word along a row and keeps the last three cells.
// From the fourth cell of a row on, each cell yields one result word: the
// right face of the second-newest-but-one cell B and the left face of cell C
// at the B|C interface, with minmod-limited depth, velocity and hydrostatic
// bed faces, saturated to their ranges, and a dry flag when B or C has zero
// depth (its velocity faces are then the cell velocities). tuser on the
// request marks the first cell of a row and clears the window first.
// Steps: a cell that yields no result goes through accept and window
// update; one that yields a result goes through accept, prep, then four
// passes (one per velocity face) of the shared 32x32 multiplier and the
// bit-serial divider, then the output load. The result sits in an output
// register, so a new cell is taken while the previous result waits; a new
// result waits only if the old one is untaken.
module shallow_water_muscl_minmod_faces_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // depth[30:0], vel_x[62:31], vel_y[94:63], bed[126:95], zero pad
   input  logic [127:0] req_tdata,
   // row_start[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // left_depth[30:0], left_vel_x[62:31], left_vel_y[94:63], left_bed[126:95],
   // right_depth[157:127], right_vel_x[189:158], right_vel_y[221:190],
   // right_bed[253:222], zero pad
   output logic [255:0] rsp_tdata,
   // dry[0]
   output logic [0:0]   rsp_tuser
);
   import swmf_pkg::*;

   cmd_type    cmd;
   status_type status;
   cell_type   in_cell;
   logic [DEPTH_W-1:0] fdep [2];
   logic [VAL_W-1:0]   fu [2];
   logic [VAL_W-1:0]   fv [2];
   logic [VAL_W-1:0]   fz [2];
   logic               dry;

   assign in_cell.h = req_tdata[30:0];
   assign in_cell.u = req_tdata[62:31];
   assign in_cell.v = req_tdata[94:63];
   assign in_cell.z = req_tdata[126:95];

   swmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swmf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_row_start (req_tuser[0]),
      .in_cell      (in_cell),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .out_fdep     (fdep),
      .out_fu       (fu),
      .out_fv       (fv),
      .out_fz       (fz),
      .out_dry      (dry)
   );

   assign rsp_tdata = {2'b00, fz[1], fv[1], fu[1], fdep[1], fz[0], fv[0], fu[0], fdep[0]};
   assign rsp_tuser = dry;

endmodule

// File: rtl/core/swmf_checker.sv
// Port-level checker of the face reconstruction unit and its bind.
`include "shallow_water_muscl_minmod_faces_unit_assert.svh"

module swmf_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [255:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);
   // stalled result word holds
   `SWMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // one cell at a time: busy after taking a word
   `SWMF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // no result can appear the cycle after a cell is taken
   `SWMF_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid))
   // reset empties the output register
   `SWMF_ASSERT_NEXT(a_rst_empty, clock, 1'b0, reset, !rsp_tvalid)
   // pad bits are zero
   `SWMF_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[255:254] == 2'b00)
endmodule

bind shallow_water_muscl_minmod_faces_unit swmf_checker u_swmf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
